// ===== design/tdad_pkg.sv =====
// Package for the table DPCM audio decoder: step tables, result type,
// start values and the per-nibble step function. No dependencies.
package tdad_pkg;

    localparam int SAMPLE_W = 16;

    // Start value of the accumulator for each mode at the head of a stream
    localparam logic signed [SAMPLE_W-1:0] ACC16_START = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] ACC8_START  = 16'sd128;

    localparam logic MODE_16BIT = 1'b0;
    localparam logic MODE_8BIT  = 1'b1;

    localparam logic [15:0] STEP16 [0:127] = '{
        16'h0000, 16'h0008, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060,
        16'h0070, 16'h0080, 16'h0090, 16'h00A0, 16'h00B0, 16'h00C0, 16'h00D0, 16'h00E0,
        16'h00F0, 16'h0100, 16'h0110, 16'h0120, 16'h0130, 16'h0140, 16'h0150, 16'h0160,
        16'h0170, 16'h0180, 16'h0190, 16'h01A0, 16'h01B0, 16'h01C0, 16'h01D0, 16'h01E0,
        16'h01F0, 16'h0200, 16'h0208, 16'h0210, 16'h0218, 16'h0220, 16'h0228, 16'h0230,
        16'h0238, 16'h0240, 16'h0248, 16'h0250, 16'h0258, 16'h0260, 16'h0268, 16'h0270,
        16'h0278, 16'h0280, 16'h0288, 16'h0290, 16'h0298, 16'h02A0, 16'h02A8, 16'h02B0,
        16'h02B8, 16'h02C0, 16'h02C8, 16'h02D0, 16'h02D8, 16'h02E0, 16'h02E8, 16'h02F0,
        16'h02F8, 16'h0300, 16'h0308, 16'h0310, 16'h0318, 16'h0320, 16'h0328, 16'h0330,
        16'h0338, 16'h0340, 16'h0348, 16'h0350, 16'h0358, 16'h0360, 16'h0368, 16'h0370,
        16'h0378, 16'h0380, 16'h0388, 16'h0390, 16'h0398, 16'h03A0, 16'h03A8, 16'h03B0,
        16'h03B8, 16'h03C0, 16'h03C8, 16'h03D0, 16'h03D8, 16'h03E0, 16'h03E8, 16'h03F0,
        16'h03F8, 16'h0400, 16'h0440, 16'h0480, 16'h04C0, 16'h0500, 16'h0540, 16'h0580,
        16'h05C0, 16'h0600, 16'h0640, 16'h0680, 16'h06C0, 16'h0700, 16'h0740, 16'h0780,
        16'h07C0, 16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h0C00, 16'h0D00, 16'h0E00,
        16'h0F00, 16'h1000, 16'h1400, 16'h1800, 16'h1C00, 16'h2000, 16'h3000, 16'h4000
    };

    localparam logic [4:0] STEP8 [0:7] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_byte;
        logic                       end_of_stream;
    } result_t;

    // One 4-bit code: add or subtract a small step, clip to 0..255
    function automatic logic [7:0] nib_step(input logic signed [15:0] acc,
                                            input logic [3:0] nib);
        logic signed [16:0] sum;
        logic [4:0]         step;
        logic [7:0]         res;
        step = nib[3] ? STEP8[3'd7 - nib[2:0]] : STEP8[nib[2:0]];
        if (nib[3])
            sum = 17'(acc) - 17'(signed'({1'b0, step}));
        else
            sum = 17'(acc) + 17'(signed'({1'b0, step}));
        if (sum < 17'sd0)
            res = 8'd0;
        else if (sum > 17'sd255)
            res = 8'd255;
        else
            res = sum[7:0];
        return res;
    endfunction

endpackage

// ===== design/tdad_if.sv =====
// Valid/ready channels of the table DPCM audio decoder: code bytes in,
// samples out, and the mode register write. Depends on tdad_pkg.
interface tdad_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       first_of_stream;
    logic       last_of_stream;

    modport source (output valid, output code_byte, output first_of_stream,
                    output last_of_stream, input ready);
    modport sink   (input valid, input code_byte, input first_of_stream,
                    input last_of_stream, output ready);
endinterface

interface tdad_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tdad_pkg::SAMPLE_W-1:0] sample;
    logic                                 last_of_byte;
    logic                                 end_of_stream;

    modport source (output valid, output sample, output last_of_byte,
                    output end_of_stream, input ready);
    modport sink   (input valid, input sample, input last_of_byte,
                    input end_of_stream, output ready);
endinterface

interface tdad_cfg_if;
    logic valid;
    logic ready;
    logic sample_mode;

    modport source (output valid, output sample_mode, input ready);
    modport sink   (input valid, input sample_mode, output ready);
endinterface

// ===== design/table_dpcm_audio_decoder_core.sv =====
// Table DPCM audio decoder core: code bytes in, audio samples out.
// A byte's first sample is registered and valid in the cycle after its transaction.
// One byte per cycle in 16-bit mode while the sample channel is ready; in 8-bit
// mode the single sample port, one sample per cycle while ready, sets the rate.
// Reset clears the accumulator to 0 and sample_mode to 16-bit mode.
// Depends on tdad_pkg, tdad_if, tdad_step, tdad_obuf.
module table_dpcm_audio_decoder_core
(
    input  logic          clk,
    input  logic          rst_n,
    tdad_code_if.sink     code_in,
    tdad_sample_if.source sample_out,
    tdad_cfg_if.sink      cfg
);

    // Mode register; software writes it only while the core is idle (not enforced by the core)
    logic mode_reg;
    logic mode_next;

    // Running accumulator, read as two's complement in both modes
    logic signed [tdad_pkg::SAMPLE_W-1:0] acc_reg;
    logic signed [tdad_pkg::SAMPLE_W-1:0] acc_next;
    logic signed [tdad_pkg::SAMPLE_W-1:0] acc_step;

    tdad_pkg::result_t res0;
    tdad_pkg::result_t res1;
    logic              can_load;
    logic              code_fire;

    // The configuration channel never stalls
    assign cfg.ready = 1'b1;
    assign mode_next = (cfg.valid && cfg.ready) ? cfg.sample_mode : mode_reg;

    // Accept a byte when the result buffer is empty or frees up this cycle, so
    // a last sample that leaves now does not hold up the next transaction
    assign code_in.ready = can_load;
    assign code_fire     = code_in.valid && code_in.ready;

    // Decode the byte straight from the channel against the current
    // accumulator; the whole step fits between the accumulator and buffer
    tdad_step u_step
    (
        .mode            (mode_reg),
        .acc             (acc_reg),
        .code_byte       (code_in.code_byte),
        .first_of_stream (code_in.first_of_stream),
        .last_of_stream  (code_in.last_of_stream),
        .res0            (res0),
        .res1            (res1),
        .acc_next        (acc_step)
    );

    // Hold the accumulator unless a byte is taken
    assign acc_next = code_fire ? acc_step : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tdad_pkg::MODE_16BIT;
            acc_reg  <= tdad_pkg::ACC16_START;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    // One result in 16-bit mode, two (high nibble first) in 8-bit mode
    tdad_obuf u_obuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (code_fire),
        .two      (mode_reg == tdad_pkg::MODE_8BIT),
        .res0     (res0),
        .res1     (res1),
        .can_load (can_load),
        .samples  (sample_out)
    );

endmodule

// ===== design/tdad_step.sv =====
// Decode datapath: applies one code byte to the accumulator and builds up
// to two results. Depends on tdad_pkg.
module tdad_step
(
    input  logic                                 mode,
    input  logic signed [tdad_pkg::SAMPLE_W-1:0] acc,
    input  logic [7:0]                           code_byte,
    input  logic                                 first_of_stream,
    input  logic                                 last_of_stream,
    output tdad_pkg::result_t                    res0,
    output tdad_pkg::result_t                    res1,
    output logic signed [tdad_pkg::SAMPLE_W-1:0] acc_next
);

    logic signed [15:0] acc_start;
    logic signed [16:0] sum16;
    logic signed [15:0] clip16;
    logic [15:0]        step16;
    logic [7:0]         hi8;
    logic [7:0]         lo8;

    always_comb
    begin
        if (first_of_stream)
            acc_start = (mode == tdad_pkg::MODE_8BIT) ? tdad_pkg::ACC8_START
                                                      : tdad_pkg::ACC16_START;
        else
            acc_start = acc;

        // 16-bit path: sign-magnitude step, saturate to signed 16 bits
        step16 = tdad_pkg::STEP16[code_byte[6:0]];
        if (code_byte[7])
            sum16 = 17'(acc_start) - 17'(signed'({1'b0, step16}));
        else
            sum16 = 17'(acc_start) + 17'(signed'({1'b0, step16}));
        if (sum16 < -17'sd32768)
            clip16 = -16'sd32768;
        else if (sum16 > 17'sd32767)
            clip16 = 16'sd32767;
        else
            clip16 = sum16[15:0];

        // 8-bit path: high nibble first, then low nibble from that result
        hi8 = tdad_pkg::nib_step(acc_start, code_byte[7:4]);
        lo8 = tdad_pkg::nib_step(signed'({8'd0, hi8}), code_byte[3:0]);

        if (mode == tdad_pkg::MODE_8BIT)
        begin
            res0.sample        = signed'({8'd0, hi8});
            res0.last_of_byte  = 1'b0;
            res0.end_of_stream = 1'b0;
            res1.sample        = signed'({8'd0, lo8});
            res1.last_of_byte  = 1'b1;
            res1.end_of_stream = last_of_stream;
            acc_next           = signed'({8'd0, lo8});
        end
        else
        begin
            res0.sample        = clip16;
            res0.last_of_byte  = 1'b1;
            res0.end_of_stream = last_of_stream;
            res1               = res0;
            acc_next           = clip16;
        end
    end

endmodule

// ===== design/tdad_obuf.sv =====
// Two-entry result buffer: holds the results of one code byte and presents
// them one per cycle, while the sample channel is ready. Depends on tdad_pkg, tdad_if.
module tdad_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              two,
    input  tdad_pkg::result_t res0,
    input  tdad_pkg::result_t res1,
    output logic              can_load,
    tdad_sample_if.source     samples
);

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    tdad_pkg::result_t head_reg;
    tdad_pkg::result_t head_next;
    tdad_pkg::result_t tail_reg;
    tdad_pkg::result_t tail_next;
    logic              fire;

    assign fire     = samples.valid && samples.ready;
    // Take a new transaction when empty or when the last entry leaves now
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && samples.ready);

    assign samples.valid         = (count_reg != 2'd0);
    assign samples.sample        = head_reg.sample;
    assign samples.last_of_byte  = head_reg.last_of_byte;
    assign samples.end_of_stream = head_reg.end_of_stream;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (load)
        begin
            head_next  = res0;
            tail_next  = res1;
            count_next = two ? 2'd2 : 2'd1;
        end
        else if (fire)
        begin
            // advance the second entry to the head
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
